/* hw/rtl/ogru_pkg.sv */
// ----------------------------------------------------------------------------
// ogru_pkg
// Shared constants, codes and types for the occupancy grid ray update block.
// ----------------------------------------------------------------------------
package ogru_pkg;

	localparam int GRID_WIDTH  = 64;
	localparam int GRID_HEIGHT = 64;
	localparam int FRAC_BITS   = 8;
	localparam int COORD_BITS  = 12;

	localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = 6;
	localparam int ROW_W      = 6;
	localparam int CELL_W     = 12;
	localparam int CFG_W      = 12;
	localparam int CNT_W      = 13;
	localparam int CLASS_W    = 2;
	localparam int REG_IDX_W  = 3;

	// walk coordinates carry one guard bit, error terms two more
	localparam int CW    = COORD_BITS + 1;
	localparam int ERR_W = COORD_BITS + 3;

	localparam logic signed [CW-1:0]     GRID_W_S   = CW'(GRID_WIDTH);
	localparam logic signed [CW-1:0]     GRID_H_S   = CW'(GRID_HEIGHT);
	localparam logic signed [CELL_W:0]   CELL_LIMIT = (CELL_W+1)'(5 << FRAC_BITS);

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FREE_DELTA    = 3'd0,
		REG_OCC_DELTA     = 3'd1,
		REG_OCC_THRESHOLD = 3'd2,
		REG_FREE_THRESHOLD = 3'd3
	} reg_idx_t;

	typedef enum logic {
		CMD_CAST = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	typedef enum logic [CLASS_W-1:0] {
		CLS_FREE     = 2'd0,
		CLS_OCCUPIED = 2'd1,
		CLS_UNKNOWN  = 2'd2
	} cell_class_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_STEP,
		ST_UPDATE,
		ST_READ,
		ST_READ_WAIT,
		ST_DONE
	} state_t;

endpackage

/* hw/rtl/ogru_ram.sv */
// ----------------------------------------------------------------------------
// ogru_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ogru_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/occupancy_grid_ray_update.sv */
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update
// Log-odds occupancy grid: casts Bresenham rays that update cells, and reads
// back single cells with their class.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   tvalid/tready      tuser command, tdata ray ends and read cell
//  m_*       out  tvalid/tready      tdata class, log-odds, cells updated
//  cfg_*     in   cfg_we             cfg_index, cfg_data (no read-back)
//
//  a cast steps over off-grid ray cells in ST_STEP and reads then writes each in-grid
//  cell of the cell memory (ST_STEP then ST_UPDATE), then passes ST_DONE
//  a read passes ST_READ and, for an in-grid cell, ST_READ_WAIT for the registered read
//  after reset the cell memory is cleared, all 4096 cells, with s_tready low
//  one result register: the next request is taken while a result waits
// ----------------------------------------------------------------------------
module occupancy_grid_ray_update (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// start_x, start_y, end_x, end_y, read_col, read_row, zero pad
	input  logic [ogru_pkg::IN_DATA_W-1:0]  s_tdata,
	// command
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// cell_class, cell_log_odds, cells_updated, zero pad
	output logic [ogru_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_we,
	input  logic [ogru_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [ogru_pkg::CFG_W-1:0]      cfg_data
);

	import ogru_pkg::*;

	state_t state_q, state_d;

	logic signed [CFG_W-1:0] free_delta_q, occ_delta_q, occ_thr_q, free_thr_q;

	logic signed [CW-1:0]    x_q, y_q, x1_q, y1_q;
	logic signed [ERR_W-1:0] dx_q, dy_q, err_q;
	logic                    x_dec_q, y_dec_q;
	logic [COL_W-1:0]        rd_col_q;
	logic [ROW_W-1:0]        rd_row_q;
	logic [ADDR_W-1:0]       clr_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CLASS_W-1:0]      res_class_q;
	logic [CELL_W-1:0]       res_lo_q;
	logic                    m_tvalid_q;
	logic [OUT_DATA_W-1:0]   m_tdata_q;

	// request fields
	logic signed [COORD_BITS-1:0] in_sx, in_sy, in_ex, in_ey;
	logic [COL_W-1:0]             in_col;
	logic [ROW_W-1:0]             in_row;
	logic signed [CW-1:0]         ax, ay, bx, by;
	logic signed [ERR_W-1:0]      ddx, ddy, adx, ady;

	assign in_sx  = s_tdata[11:0];
	assign in_sy  = s_tdata[23:12];
	assign in_ex  = s_tdata[35:24];
	assign in_ey  = s_tdata[47:36];
	assign in_col = s_tdata[53:48];
	assign in_row = s_tdata[59:54];

	assign ax  = CW'(in_sx);
	assign ay  = CW'(in_sy);
	assign bx  = CW'(in_ex);
	assign by  = CW'(in_ey);
	assign ddx = ERR_W'(bx) - ERR_W'(ax);
	assign ddy = ERR_W'(by) - ERR_W'(ay);
	assign adx = ddx[ERR_W-1] ? -ddx : ddx;
	assign ady = ddy[ERR_W-1] ? -ddy : ddy;

	// walk step unit
	logic                    at_end, in_grid;
	logic signed [ERR_W:0]   e2;
	logic                    step_x, step_y;
	logic signed [ERR_W-1:0] err_nxt;
	logic signed [CW-1:0]    x_nxt, y_nxt;

	assign at_end  = (x_q == x1_q) && (y_q == y1_q);
	assign in_grid = (x_q >= 0) && (x_q < GRID_W_S) && (y_q >= 0) && (y_q < GRID_H_S);
	assign e2      = {err_q, 1'b0};
	assign step_x  = e2 >= (ERR_W+1)'(dy_q);
	assign step_y  = e2 <= (ERR_W+1)'(dx_q);
	assign err_nxt = err_q + (step_x ? dy_q : '0) + (step_y ? dx_q : '0);
	assign x_nxt   = step_x ? (x_dec_q ? x_q - CW'(1) : x_q + CW'(1)) : x_q;
	assign y_nxt   = step_y ? (y_dec_q ? y_q - CW'(1) : y_q + CW'(1)) : y_q;

	// cell update: add and clamp
	logic [CELL_W-1:0]       rd_data;
	logic signed [CELL_W-1:0] cell_val, delta;
	logic signed [CELL_W:0]  cell_sum;
	logic signed [CELL_W-1:0] cell_new;

	assign cell_val = rd_data;
	assign delta    = at_end ? occ_delta_q : free_delta_q;
	assign cell_sum = (CELL_W+1)'(cell_val) + (CELL_W+1)'(delta);

	always_comb begin
		if (cell_sum > CELL_LIMIT) begin
			cell_new = CELL_W'(CELL_LIMIT);
		end else if (cell_sum < -CELL_LIMIT) begin
			cell_new = CELL_W'(-CELL_LIMIT);
		end else begin
			cell_new = CELL_W'(cell_sum);
		end
	end

	// read class
	logic                     rd_in_grid;
	logic [CLASS_W-1:0]       rd_class;

	assign rd_in_grid = ({1'b0, rd_col_q} < (COL_W+1)'(GRID_WIDTH))
		&& ({1'b0, rd_row_q} < (ROW_W+1)'(GRID_HEIGHT));

	always_comb begin
		if (cell_val > occ_thr_q) begin
			rd_class = CLS_OCCUPIED;
		end else if (cell_val < free_thr_q) begin
			rd_class = CLS_FREE;
		end else begin
			rd_class = CLS_UNKNOWN;
		end
	end

	// memory ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr, walk_addr, rd_addr;
	logic [CELL_W-1:0] ram_wdata;

	assign walk_addr = ADDR_W'(ADDR_W'(y_q) * ADDR_W'(GRID_WIDTH)) + ADDR_W'(x_q);
	assign rd_addr   = ADDR_W'(ADDR_W'(rd_row_q) * ADDR_W'(GRID_WIDTH)) + ADDR_W'(rd_col_q);
	assign ram_raddr = (state_q == ST_READ) ? rd_addr : walk_addr;
	assign ram_we    = (state_q == ST_CLEAR) || (state_q == ST_UPDATE);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : walk_addr;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : cell_new;

	ogru_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	logic accept, slot_free;

	assign accept    = s_tvalid && s_tready;
	assign slot_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_W'(CELL_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (s_tuser == CMD_READ) ? ST_READ : ST_STEP;
				end
			end
			ST_STEP: begin
				if (in_grid) begin
					state_d = ST_UPDATE;
				end else if (at_end) begin
					state_d = ST_DONE;
				end
			end
			ST_UPDATE: begin
				state_d = at_end ? ST_DONE : ST_STEP;
			end
			ST_READ: begin
				state_d = rd_in_grid ? ST_READ_WAIT : ST_DONE;
			end
			ST_READ_WAIT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			m_tvalid_q   <= 1'b0;
			free_delta_q <= -12'sd102;
			occ_delta_q  <= 12'sd217;
			occ_thr_q    <= 12'sd158;
			free_thr_q   <= -12'sd158;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_FREE_DELTA:     free_delta_q <= cfg_data;
					REG_OCC_DELTA:      occ_delta_q  <= cfg_data;
					REG_OCC_THRESHOLD:  occ_thr_q    <= cfg_data;
					REG_FREE_THRESHOLD: free_thr_q   <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_DONE && slot_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					x_q         <= ax;
					y_q         <= ay;
					x1_q        <= bx;
					y1_q        <= by;
					dx_q        <= adx;
					dy_q        <= -ady;
					err_q       <= adx - ady;
					x_dec_q     <= !(ax < bx);
					y_dec_q     <= !(ay < by);
					rd_col_q    <= in_col;
					rd_row_q    <= in_row;
					cnt_q       <= '0;
					res_class_q <= (s_tuser == CMD_READ) ? CLS_UNKNOWN : '0;
					res_lo_q    <= '0;
				end
			end
			ST_STEP: begin
				if (!in_grid && !at_end) begin
					x_q   <= x_nxt;
					y_q   <= y_nxt;
					err_q <= err_nxt;
				end
			end
			ST_UPDATE: begin
				cnt_q <= cnt_q + 1'b1;
				if (!at_end) begin
					x_q   <= x_nxt;
					y_q   <= y_nxt;
					err_q <= err_nxt;
				end
			end
			ST_READ_WAIT: begin
				res_class_q <= rd_class;
				res_lo_q    <= cell_val;
			end
			ST_DONE: begin
				if (slot_free) begin
					m_tdata_q <= OUT_DATA_W'({cnt_q, res_lo_q, res_class_q});
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* hw/rtl/ogru_checker.sv */
// ----------------------------------------------------------------------------
// ogru_checker
// Port-level checks for the occupancy grid ray update block.
// ----------------------------------------------------------------------------
module ogru_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [ogru_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic                            s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [ogru_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                            cfg_we,
	input logic [ogru_pkg::REG_IDX_W-1:0]  cfg_index,
	input logic [ogru_pkg::CFG_W-1:0]      cfg_data
);

	import ogru_pkg::*;

	// one request at a time
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

	a_class_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[1:0] == CLS_FREE) || (m_tdata[1:0] == CLS_OCCUPIED)
			|| (m_tdata[1:0] == CLS_UNKNOWN)))
		else $error("bad cell class");

	// cast results carry no cell, read results carry no count
	a_fields_split: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[26:14] == '0) || (m_tdata[13:0] == '0)))
		else $error("cast and read fields mixed");

endmodule

bind occupancy_grid_ray_update ogru_checker u_ogru_checker (.*);

/* verif/tb_occupancy_grid_ray_update.sv */
// ----------------------------------------------------------------------------
// tb_occupancy_grid_ray_update
// Drives ray casts and cell reads into the occupancy grid and compares every
// result against a shadow grid updated by a line-walking predictor. Register
// settings change between phases, and both stream sides stall in random
// bursts except in the third and the last phase.
// ----------------------------------------------------------------------------
module tb_occupancy_grid_ray_update;
	import ogru_pkg::*;

	localparam int CELL_MAX     = 5 << FRAC_BITS;
	localparam int PHASE_ITEMS  = 170;
	localparam int SETTLE_TICKS = 8;
	// covers a full-range ray and the clear after reset, during which nothing moves
	localparam int QUIET_LIMIT  = 25000;

	typedef struct packed {
		cmd_t                          cmd;
		logic signed [COORD_BITS-1:0] x0;
		logic signed [COORD_BITS-1:0] y0;
		logic signed [COORD_BITS-1:0] x1;
		logic signed [COORD_BITS-1:0] y1;
		logic [COL_W-1:0]             col;
		logic [ROW_W-1:0]             row;
	} grid_req_t;

	// same bit order as the low bits of m_tdata
	typedef struct packed {
		logic [CNT_W-1:0]         updated;
		logic signed [CELL_W-1:0] log_odds;
		cell_class_t              cls;
	} grid_reply_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data  = '0;

	logic signed [CELL_W-1:0] shadow_grid [CELL_COUNT];
	int ray_free_delta = -102;
	int ray_hit_delta  = 217;
	int occ_level      = 158;
	int free_level     = -158;

	grid_req_t   queued_commands [$];
	grid_reply_t predicted_replies [$];
	grid_req_t   in_flight;

	int idle_pct = 20;
	int src_gap  = 0;
	int sink_gap = 0;
	int quiet_cycles = 0;
	int fail_count = 0;
	int casts_sent = 0;
	int reads_sent = 0;
	int cells_written = 0;
	int clamp_hits = 0;
	int settings_used = 1;

	occupancy_grid_ray_update dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int bump_cell(input int col, input int row, input int delta);
		int v;
		if (col < 0 || col >= GRID_WIDTH || row < 0 || row >= GRID_HEIGHT)
			return 0;
		v = shadow_grid[row * GRID_WIDTH + col] + delta;
		if (v > CELL_MAX) begin
			v = CELL_MAX;
			clamp_hits++;
		end
		if (v < -CELL_MAX) begin
			v = -CELL_MAX;
			clamp_hits++;
		end
		shadow_grid[row * GRID_WIDTH + col] = CELL_W'(v);
		return 1;
	endfunction

	// updates the shadow grid for a cast and builds the expected reply
	function automatic grid_reply_t apply_command(input grid_req_t c);
		grid_reply_t r;
		int x, y, x1, y1, dx, dy, sx, sy, err, e2, v, n;
		bit walking;
		r = '0;
		if (c.cmd == CMD_CAST) begin
			x  = $signed(c.x0);
			y  = $signed(c.y0);
			x1 = $signed(c.x1);
			y1 = $signed(c.y1);
			sx = (x < x1) ? 1 : -1;
			sy = (y < y1) ? 1 : -1;
			dx = (x1 > x) ? x1 - x : x - x1;
			dy = (y1 > y) ? y - y1 : y1 - y;
			err = dx + dy;
			n = 0;
			walking = 1'b1;
			while (walking) begin
				if (x == x1 && y == y1) begin
					n += bump_cell(x, y, ray_hit_delta);
					walking = 1'b0;
				end else begin
					n += bump_cell(x, y, ray_free_delta);
					e2 = 2 * err;
					if (e2 >= dy) begin
						err += dy;
						x += sx;
					end
					if (e2 <= dx) begin
						err += dx;
						y += sy;
					end
				end
			end
			cells_written += n;
			r.updated = CNT_W'(n);
		end else begin
			v = shadow_grid[int'(c.row) * GRID_WIDTH + int'(c.col)];
			r.log_odds = CELL_W'(v);
			if (v > occ_level)
				r.cls = CLS_OCCUPIED;
			else if (v < free_level)
				r.cls = CLS_FREE;
			else
				r.cls = CLS_UNKNOWN;
		end
		return r;
	endfunction

	function automatic void push_cast(input int x0, input int y0, input int x1, input int y1);
		grid_req_t r;
		r.cmd = CMD_CAST;
		r.x0  = COORD_BITS'(x0);
		r.y0  = COORD_BITS'(y0);
		r.x1  = COORD_BITS'(x1);
		r.y1  = COORD_BITS'(y1);
		r.col = COL_W'($urandom);
		r.row = ROW_W'($urandom);
		queued_commands.insert(queued_commands.size(), r);
	endfunction

	function automatic void push_read(input int col, input int row);
		grid_req_t r;
		r.cmd = CMD_READ;
		r.x0  = COORD_BITS'($urandom);
		r.y0  = COORD_BITS'($urandom);
		r.x1  = COORD_BITS'($urandom);
		r.y1  = COORD_BITS'($urandom);
		r.col = COL_W'(col);
		r.row = ROW_W'(row);
		queued_commands.insert(queued_commands.size(), r);
	endfunction

	// call aligned to a rising edge; the shadow copy changes when the write lands
	task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input int val);
		logic signed [CFG_W-1:0] word;
		word = CFG_W'(val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		@(posedge clk);
		case (idx)
			REG_FREE_DELTA:     ray_free_delta = word;
			REG_OCC_DELTA:      ray_hit_delta = word;
			REG_OCC_THRESHOLD:  occ_level = word;
			REG_FREE_THRESHOLD: free_level = word;
			default: ;
		endcase
	endtask

	task automatic settle();
		@(negedge clk);
		while (queued_commands.size() != 0 || s_tvalid || predicted_replies.size() != 0)
			@(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
		@(posedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predicted_replies.insert(predicted_replies.size(), apply_command(in_flight));
				if (in_flight.cmd == CMD_CAST)
					casts_sent++;
				else
					reads_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (queued_commands.size() != 0) begin
					in_flight = queued_commands.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= in_flight.cmd;
					s_tdata  <= IN_DATA_W'({in_flight.row, in_flight.col, in_flight.y1,
						in_flight.x1, in_flight.y0, in_flight.x0});
					if ($urandom_range(0, 99) < idle_pct)
						src_gap = $urandom_range(1, 13);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and back-pressure
	always @(posedge clk) begin
		grid_reply_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(grid_reply_t)-1:0];
				if (predicted_replies.size() == 0) begin
					$error("result with no request outstanding: tdata %h", m_tdata);
					fail_count++;
				end else begin
					want = predicted_replies.pop_front();
					if (got.cls !== want.cls) begin
						$error("cell_class expected %0d got %0d", want.cls, got.cls);
						fail_count++;
					end
					if (got.log_odds !== want.log_odds) begin
						$error("cell_log_odds expected %0d got %0d", want.log_odds, got.log_odds);
						fail_count++;
					end
					if (got.updated !== want.updated) begin
						$error("cells_updated expected %0d got %0d", want.updated, got.updated);
						fail_count++;
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 399) < idle_pct) begin
				sink_gap = $urandom_range(0, 12);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("no request or result moved for %0d cycles", QUIET_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int phase, k, pick, ax, ay;
		for (k = 0; k < CELL_COUNT; k++)
			shadow_grid[k] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// the block clears its cell memory before taking requests
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);

		// reset register values
		push_read(0, 0);
		repeat (6) push_cast(10, 10, 10, 10);  // single cell, drives into the upper clamp
		push_read(10, 10);
		push_cast(-10, 3, 70, 3);
		push_cast(70, 3, -10, 3);
		push_cast(7, 80, 7, -5);
		push_cast(0, 0, 63, 63);
		push_cast(63, 0, 0, 63);
		push_cast(2, 1, 40, 9);
		push_cast(30, 50, 25, 2);
		push_cast(-2048, -2048, 2047, 2047);
		push_cast(2047, -2048, -2048, 2047);
		push_cast(2047, 2047, 2047, 2047);
		push_cast(-1, -1, -30, -40);
		push_cast(64, 10, 63, 10);
		push_read(20, 3);
		push_read(7, 40);
		push_read(63, 63);
		push_read(0, 63);
		push_read(63, 0);
		settle();

		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					idle_pct = 30;
					for (k = 0; k <= int'(REG_FREE_THRESHOLD); k++)
						set_reg(REG_IDX_W'(k), int'($urandom_range(0, 2560)) - 1280);
				end
				1: begin
					idle_pct = 15;
					set_reg(REG_FREE_DELTA, -1280);
					set_reg(REG_OCC_DELTA, 1280);
					set_reg(REG_OCC_THRESHOLD, 1280);
					set_reg(REG_FREE_THRESHOLD, -1280);
					set_reg(REG_IDX_W'(int'(REG_FREE_THRESHOLD) + $urandom_range(1, 4)), $urandom);
				end
				2: begin
					idle_pct = 0;
					set_reg(REG_FREE_DELTA, 1280);
					set_reg(REG_OCC_DELTA, -1280);
					set_reg(REG_OCC_THRESHOLD, -1280);
					set_reg(REG_FREE_THRESHOLD, 1280);
				end
				3: begin
					idle_pct = 40;
					for (k = 0; k <= int'(REG_FREE_THRESHOLD); k++)
						set_reg(REG_IDX_W'(k), int'($urandom_range(0, 2560)) - 1280);
					set_reg(REG_IDX_W'(int'(REG_FREE_THRESHOLD) + $urandom_range(1, 4)), $urandom);
				end
				default: begin
					idle_pct = 0;
					set_reg(REG_FREE_DELTA, -102);
					set_reg(REG_OCC_DELTA, 217);
					set_reg(REG_OCC_THRESHOLD, 158);
					set_reg(REG_FREE_THRESHOLD, -158);
				end
			endcase
			cfg_we <= 1'b0;
			settings_used++;

			for (k = 0; k < PHASE_ITEMS; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 15)
					push_read($urandom_range(0, 15), $urandom_range(0, 15));
				else if (pick < 30)
					push_read($urandom_range(0, 63), $urandom_range(0, 63));
				else if (pick < 33)
					push_cast($urandom, $urandom, $urandom, $urandom);
				else if (pick < 38) begin
					ax = int'($urandom_range(0, 19)) - 2;
					ay = int'($urandom_range(0, 19)) - 2;
					push_cast(ax, ay, ax, ay);
				end else if (pick < 65)
					push_cast($urandom_range(0, 15), $urandom_range(0, 15),
						$urandom_range(0, 15), $urandom_range(0, 15));
				else
					push_cast(int'($urandom_range(0, 79)) - 8, int'($urandom_range(0, 79)) - 8,
						int'($urandom_range(0, 79)) - 8, int'($urandom_range(0, 79)) - 8);
			end
			settle();
		end

		$display("ran %0d ray casts writing %0d cells (%0d hit the clamp) and %0d cell reads",
			casts_sent, cells_written, clamp_hits, reads_sent);
		$display("across %0d register settings, delta and threshold extremes included",
			settings_used);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/ogru_pkg.sv
hw/rtl/ogru_ram.sv
hw/rtl/occupancy_grid_ray_update.sv
hw/rtl/ogru_checker.sv
verif/tb_occupancy_grid_ray_update.sv
